/* rtl/ccs_pkg.sv */
`default_nettype none

package ccs_pkg;

  // Scan modes
  localparam logic [1:0] ModeCode   = 2'd0;
  localparam logic [1:0] ModeLine   = 2'd1;
  localparam logic [1:0] ModeBlock  = 2'd2;
  localparam logic [1:0] ModeString = 2'd3;

  // Characters the scanner reacts to
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChQuote  = 8'h22;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } ccs_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } ccs_out_t;

endpackage

`default_nettype wire

/* rtl/c_comment_stripper.sv */
// C comment stripper.
// The input channel (in_valid_i/in_ready_o/in_data_i) carries one source byte
// per beat, with end_of_text set on the final byte of a text. The output
// channel (out_valid_o/out_ready_i/out_data_o) carries the bytes that remain
// after C and C++ comments are removed; each input beat yields zero, one or two
// output beats, and run_last marks the last output beat of an input beat.
// The scanner state (mode and previous byte) is updated in the cycle the input
// beat is accepted, and its results are loaded into a two-entry output buffer.
// The first output beat of an accepted input beat appears in the cycle after it is accepted.
// Throughput is one input beat per cycle while every input yields at most one
// byte and the receiver takes a beat every cycle; an input that yields two
// bytes holds the input off until the two-entry output buffer drains to at
// most one entry with a pop in progress, and only then is the next beat taken.
// When the receiver stalls, the buffered beats hold and in_ready_o drops once
// the buffer cannot take a full two-byte result.
// Reset puts the scanner in code mode with a zero previous byte and empties
// the output buffer; end_of_text does the same to the scanner after its byte.
`default_nettype none

module c_comment_stripper (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire ccs_pkg::ccs_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output ccs_pkg::ccs_out_t     out_data_o
);

  logic [1:0] mode_q, mode_d;
  logic [7:0] prev_q, prev_d;
  logic [1:0] count_q, count_d;
  logic [7:0] buf0_q, buf0_d, buf1_q, buf1_d;
  logic       last0_q, last0_d;

  logic       in_fire, out_fire;
  logic [1:0] num_res;
  logic [7:0] res0, res1;
  logic [7:0] cur;
  logic [1:0] scan_mode;
  logic [7:0] next_prev;

  assign cur      = in_data_i.in_byte;
  assign out_fire = out_valid_o && out_ready_i;
  // A beat is taken only when a two-byte result surely fits.
  assign in_ready_o = (count_q == 2'd0) || ((count_q == 2'd1) && out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    num_res   = 2'd0;
    res0      = cur;
    res1      = cur;
    scan_mode = mode_q;
    next_prev = cur;
    case (mode_q)
      ccs_pkg::ModeLine: begin
        if (prev_q != ccs_pkg::ChBslash &&
            (cur == ccs_pkg::ChLf || cur == ccs_pkg::ChCr)) begin
          num_res   = 2'd1;
          next_prev = '0;
          scan_mode = ccs_pkg::ModeCode;
        end
      end
      ccs_pkg::ModeBlock: begin
        if (prev_q == ccs_pkg::ChStar && cur == ccs_pkg::ChSlash) begin
          next_prev = '0;
          scan_mode = ccs_pkg::ModeCode;
        end
      end
      ccs_pkg::ModeString: begin
        if (prev_q == ccs_pkg::ChBslash) begin
          // Escaped pair goes out as a unit and cannot close the string.
          num_res   = 2'd2;
          res0      = prev_q;
          next_prev = '0;
        end else if (cur != ccs_pkg::ChBslash) begin
          num_res = 2'd1;
          if (cur == ccs_pkg::ChQuote) scan_mode = ccs_pkg::ModeCode;
        end
      end
      default: begin
        if (prev_q == ccs_pkg::ChSlash) begin
          if (cur == ccs_pkg::ChSlash) begin
            scan_mode = ccs_pkg::ModeLine;
          end else if (cur == ccs_pkg::ChStar) begin
            // Clearing prev keeps the opening star from closing the comment.
            scan_mode = ccs_pkg::ModeBlock;
            next_prev = '0;
          end else begin
            num_res = 2'd2;
            res0    = prev_q;
          end
        end else if (cur != ccs_pkg::ChSlash) begin
          num_res = 2'd1;
          if (cur == ccs_pkg::ChQuote) scan_mode = ccs_pkg::ModeString;
        end
      end
    endcase
  end

  always_comb begin
    mode_d  = mode_q;
    prev_d  = prev_q;
    count_d = count_q;
    buf0_d  = buf0_q;
    buf1_d  = buf1_q;
    last0_d = last0_q;
    if (out_fire) begin
      count_d = count_q - 2'd1;
      buf0_d  = buf1_q;
      last0_d = 1'b1;
    end
    if (in_fire) begin
      if (in_data_i.end_of_text) begin
        mode_d = ccs_pkg::ModeCode;
        prev_d = '0;
      end else begin
        mode_d = scan_mode;
        prev_d = next_prev;
      end
      // The buffer is empty after this cycle's pop whenever a beat is taken.
      count_d = num_res;
      buf0_d  = res0;
      buf1_d  = res1;
      last0_d = (num_res != 2'd2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ccs_pkg::ModeCode;
      prev_q  <= '0;
      count_q <= '0;
    end else begin
      mode_q  <= mode_d;
      prev_q  <= prev_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf0_q  <= buf0_d;
    buf1_q  <= buf1_d;
    last0_q <= last0_d;
  end

  assign out_valid_o         = (count_q != 2'd0);
  assign out_data_o.out_byte = buf0_q;
  assign out_data_o.run_last = last0_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("output buffer count out of range");

  a_pair_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && num_res == 2'd2) |=> (count_q == 2'd2 && !out_data_o.run_last))
    else $error("two-byte result not buffered as a pair");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd2 && !out_ready_i) |=> (count_q == 2'd2 && $stable(buf0_q)))
    else $error("buffered beat changed under stall");

  a_no_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd2) |-> !in_ready_o)
    else $error("input taken while buffer full");

endmodule

`default_nettype wire
